FILE: src/circular_caller_id_queue_assert.svh
`ifndef CIRCULAR_CALLER_ID_QUEUE_ASSERT_SVH
`define CIRCULAR_CALLER_ID_QUEUE_ASSERT_SVH

// Property checked on every rising edge while out of reset.
`define CCQ_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Implication checked on the following edge while out of reset.
`define CCQ_ASSERT_NEXT(label, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
    else $error(msg);

`endif

FILE: src/ccq_pkg.sv
package ccq_pkg;

  localparam int DEPTH       = 10;
  localparam int PTR_W       = $clog2(DEPTH);
  localparam int FILL_W      = $clog2(DEPTH + 1);
  localparam int NUM_W       = 64;
  localparam int ENTRY_W     = 35;
  localparam int OUT_TDATA_W = ((ENTRY_W + 7) / 8) * 8;
  localparam int CQ_DEPTH    = 2;
  localparam int CQ_PTR_W    = $clog2(CQ_DEPTH);
  localparam int CQ_CNT_W    = $clog2(CQ_DEPTH + 1);

  localparam logic signed [NUM_W-1:0] NUM_MIN = 64'sd1000000000;
  localparam logic signed [NUM_W-1:0] NUM_MAX = 64'sd9999999999;

  typedef enum logic [1:0] {
    OP_ENQ  = 2'd0,
    OP_DEQ  = 2'd1,
    OP_VIEW = 2'd2
  } op_t;

  typedef enum logic [2:0] {
    ST_ACCEPTED = 3'd0,
    ST_FULL     = 3'd1,
    ST_INVALID  = 3'd2,
    ST_EMPTY    = 3'd3,
    ST_SHOWN    = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_DEQ,
    BK_VIEW
  } bk_state_t;

  typedef struct packed {
    op_t                       op;
    logic                      num_ok;
    logic signed [ENTRY_W-1:0] number;
  } cmd_t;

  function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] p);
    logic [PTR_W-1:0] r;
    if (p == PTR_W'(DEPTH - 1)) begin
      r = '0;
    end else begin
      r = p + 1'b1;
    end
    return r;
  endfunction

endpackage

FILE: src/ccq_front.sv
module ccq_front
  import ccq_pkg::*;
(
  input  logic             in_tvalid,
  output logic             in_tready,
  input  logic [NUM_W-1:0] in_tdata,
  input  logic [1:0]       in_tuser,
  input  logic             q_full,
  output logic             q_push,
  output cmd_t             q_cmd
);

  logic signed [NUM_W-1:0] num;
  logic                    pos_ok;
  logic                    neg_ok;
  logic                    is_op;

  assign num    = $signed(in_tdata);
  assign pos_ok = (num >= NUM_MIN) && (num <= NUM_MAX);
  assign neg_ok = (num <= -NUM_MIN) && (num >= -NUM_MAX);

  always_comb begin
    case (in_tuser)
      OP_ENQ, OP_DEQ, OP_VIEW: is_op = 1'b1;
      default:                 is_op = 1'b0;
    endcase
  end

  assign in_tready    = !q_full;
  assign q_push       = in_tvalid && !q_full && is_op;
  assign q_cmd.op     = op_t'(in_tuser);
  assign q_cmd.num_ok = pos_ok || neg_ok;
  assign q_cmd.number = num[ENTRY_W-1:0];

endmodule

FILE: src/ccq_cmd_fifo.sv
module ccq_cmd_fifo
  import ccq_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  cmd_t push_cmd,
  output logic full,
  input  logic pop,
  output cmd_t pop_cmd,
  output logic empty
);

  cmd_t                q_r [CQ_DEPTH];
  logic [CQ_PTR_W-1:0] wr_ptr_r;
  logic [CQ_PTR_W-1:0] wr_ptr_nxt;
  logic [CQ_PTR_W-1:0] rd_ptr_r;
  logic [CQ_PTR_W-1:0] rd_ptr_nxt;
  logic [CQ_CNT_W-1:0] cnt_r;
  logic [CQ_CNT_W-1:0] cnt_nxt;
  logic                do_push;
  logic                do_pop;

  assign full    = (cnt_r == CQ_CNT_W'(CQ_DEPTH));
  assign empty   = (cnt_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign pop_cmd = q_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      q_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

FILE: src/ccq_back.sv
module ccq_back
  import ccq_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   q_empty,
  input  cmd_t                   q_cmd,
  output logic                   q_pop,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,
  output logic [2:0]             out_tuser,
  output logic                   out_tlast
);

  logic signed [ENTRY_W-1:0] slots_r [DEPTH];
  logic signed [ENTRY_W-1:0] rd_data_r;

  bk_state_t         state_r;
  bk_state_t         state_nxt;
  logic [PTR_W-1:0]  head_r;
  logic [PTR_W-1:0]  head_nxt;
  logic [PTR_W-1:0]  tail_r;
  logic [PTR_W-1:0]  tail_nxt;
  logic [FILL_W-1:0] fill_r;
  logic [FILL_W-1:0] fill_nxt;
  logic [PTR_W-1:0]  idx_r;
  logic [PTR_W-1:0]  idx_nxt;
  logic [FILL_W-1:0] cnt_r;
  logic [FILL_W-1:0] cnt_nxt;

  logic                      out_valid_r;
  logic                      out_valid_nxt;
  status_t                   out_status_r;
  logic signed [ENTRY_W-1:0] out_entry_r;
  logic                      out_last_r;

  logic                      out_free;
  logic                      take;
  logic                      res_load;
  status_t                   res_status;
  logic signed [ENTRY_W-1:0] res_entry;
  logic                      res_last;
  logic                      wr_en;
  logic                      rd_en;
  logic [PTR_W-1:0]          rd_addr;

  assign out_free = !out_valid_r || out_tready;
  assign take     = !q_empty && out_free;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      BK_IDLE: begin
        if (take && fill_r != '0) begin
          case (q_cmd.op)
            OP_DEQ:  state_nxt = BK_DEQ;
            OP_VIEW: state_nxt = BK_VIEW;
            default: state_nxt = BK_IDLE;
          endcase
        end
      end
      BK_DEQ: begin
        if (out_free) begin
          state_nxt = BK_IDLE;
        end
      end
      BK_VIEW: begin
        if (out_free && cnt_r == '0) begin
          state_nxt = BK_IDLE;
        end
      end
      default: state_nxt = BK_IDLE;
    endcase
  end

  always_comb begin
    q_pop      = 1'b0;
    res_load   = 1'b0;
    res_status = ST_ACCEPTED;
    res_entry  = '0;
    res_last   = 1'b1;
    wr_en      = 1'b0;
    rd_en      = 1'b0;
    rd_addr    = head_r;
    head_nxt   = head_r;
    tail_nxt   = tail_r;
    fill_nxt   = fill_r;
    idx_nxt    = idx_r;
    cnt_nxt    = cnt_r;
    case (state_r)
      BK_IDLE: begin
        if (take) begin
          q_pop = 1'b1;
          case (q_cmd.op)
            OP_ENQ: begin
              res_load = 1'b1;
              if (fill_r == FILL_W'(DEPTH)) begin
                res_status = ST_FULL;
              end else if (!q_cmd.num_ok) begin
                res_status = ST_INVALID;
              end else begin
                wr_en    = 1'b1;
                tail_nxt = next_ptr(tail_r);
                fill_nxt = fill_r + 1'b1;
              end
            end
            OP_DEQ: begin
              if (fill_r == '0) begin
                res_load   = 1'b1;
                res_status = ST_EMPTY;
              end else begin
                rd_en    = 1'b1;
                head_nxt = next_ptr(head_r);
                fill_nxt = fill_r - 1'b1;
              end
            end
            OP_VIEW: begin
              if (fill_r == '0) begin
                res_load   = 1'b1;
                res_status = ST_EMPTY;
              end else begin
                rd_en   = 1'b1;
                idx_nxt = next_ptr(head_r);
                cnt_nxt = fill_r - 1'b1;
              end
            end
            default: q_pop = 1'b1;
          endcase
        end
      end
      BK_DEQ: begin
        if (out_free) begin
          res_load  = 1'b1;
          res_entry = rd_data_r;
        end
      end
      BK_VIEW: begin
        if (out_free) begin
          res_load   = 1'b1;
          res_status = ST_SHOWN;
          res_entry  = rd_data_r;
          res_last   = (cnt_r == '0);
          if (cnt_r != '0) begin
            rd_en   = 1'b1;
            rd_addr = idx_r;
            idx_nxt = next_ptr(idx_r);
            cnt_nxt = cnt_r - 1'b1;
          end
        end
      end
      default: q_pop = 1'b0;
    endcase
  end

  always_comb begin
    if (res_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_IDLE;
      head_r      <= '0;
      tail_r      <= '0;
      fill_r      <= '0;
      idx_r       <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      fill_r      <= fill_nxt;
      idx_r       <= idx_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      out_status_r <= res_status;
      out_entry_r  <= res_entry;
      out_last_r   <= res_last;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      slots_r[tail_r] <= q_cmd.number;
    end
    if (rd_en) begin
      rd_data_r <= slots_r[rd_addr];
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(OUT_TDATA_W - ENTRY_W){1'b0}}, out_entry_r};
  assign out_tuser  = out_status_r;
  assign out_tlast  = out_last_r;

endmodule

FILE: src/circular_caller_id_queue.sv
// Circular queue of ten-digit caller numbers, up to DEPTH entries.
// Input channel: in_tuser selects the operation (enqueue, dequeue, view) and
// in_tdata carries the signed caller number, which only enqueue examines.
// Operation code 3 is taken and ignored without any result beat.
// Output channel: one beat per result; out_tuser holds the status, out_tdata
// the removed or shown number (zero otherwise), and out_tlast marks the
// final beat caused by one input beat.
// Accepted beats pass through a two-entry command queue to the executing
// back end, so the input side keeps taking beats while a result waits.
// An accepted beat is registered in the command queue, then executed by the
// back end into the output register; a dequeue or view first reads the slot
// store through its registered read port. The back end executes one enqueue
// per cycle while the output is free; a dequeue or view keeps it busy until its last beat is loaded.
// Reset empties the queue; slot contents are not cleared.
// When the receiver holds out_tready low, the result beat holds and the
// back end stops; the input side stalls once the command queue is full.
module circular_caller_id_queue
  import ccq_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [NUM_W-1:0]       in_tdata,   // number
  input  logic [1:0]             in_tuser,   // func
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,  // entry, zero padding
  output logic [2:0]             out_tuser,  // status
  output logic                   out_tlast
);

  logic q_full;
  logic q_push;
  cmd_t q_push_cmd;
  logic q_pop;
  cmd_t q_pop_cmd;
  logic q_empty;

  ccq_front u_front (
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_cmd     (q_push_cmd)
  );

  ccq_cmd_fifo u_cmd_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_cmd (q_push_cmd),
    .full     (q_full),
    .pop      (q_pop),
    .pop_cmd  (q_pop_cmd),
    .empty    (q_empty)
  );

  ccq_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_empty    (q_empty),
    .q_cmd      (q_pop_cmd),
    .q_pop      (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule

FILE: src/ccq_checker.sv
`include "circular_caller_id_queue_assert.svh"

module ccq_checker
  import ccq_pkg::*;
(
  input logic                   clk,
  input logic                   rst_n,
  input logic                   out_tvalid,
  input logic                   out_tready,
  input logic [OUT_TDATA_W-1:0] out_tdata,
  input logic [2:0]             out_tuser,
  input logic                   out_tlast
);

  logic                           status_beat;
  logic                           plain_beat;
  logic                           stalled;
  logic [OUT_TDATA_W-ENTRY_W-1:0] pad_bits;
  logic [OUT_TDATA_W+3:0]         beat_bits;

  assign status_beat = out_tvalid && (out_tuser == ST_FULL || out_tuser == ST_INVALID ||
                                      out_tuser == ST_EMPTY);
  assign plain_beat  = out_tvalid && out_tuser != ST_SHOWN;
  assign stalled     = out_tvalid && !out_tready;
  assign pad_bits    = out_tdata[OUT_TDATA_W-1:ENTRY_W];
  assign beat_bits   = {out_tlast, out_tuser, out_tdata};

  `CCQ_ASSERT(a_single_beat_last, plain_beat |-> out_tlast, "status beat without last")
  `CCQ_ASSERT(a_status_no_entry, status_beat |-> out_tdata == '0, "status beat carries an entry")
  `CCQ_ASSERT(a_pad_zero, out_tvalid |-> pad_bits == '0, "padding bits set")
  `CCQ_ASSERT_NEXT(a_out_hold, stalled, out_tvalid && $stable(beat_bits), "stalled beat changed")

endmodule

bind circular_caller_id_queue ccq_checker u_ccq_checker (.*);
